FILE: src/vector_pairwise_accumulate_defines.svh
// Assertion macros for the vector pairwise accumulate block.
`ifndef VECTOR_PAIRWISE_ACCUMULATE_DEFINES_SVH
`define VECTOR_PAIRWISE_ACCUMULATE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define VPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpa assertion failed");
// Assert that a condition implies a consequence in the cycle after.
`define VPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpa assertion failed");
`endif

FILE: src/vpa_pkg.sv
// Package for the vector pairwise accumulate block: codes and widths.
package vpa_pkg;
  localparam int DataW = 32;
  localparam int FracBitsDefault = 16;
  localparam logic [2:0] EOP_SUM  = 3'd0;
  localparam logic [2:0] EOP_DIFF = 3'd1;
  localparam logic [2:0] EOP_MUL  = 3'd2;
  localparam logic [2:0] EOP_DIV  = 3'd3;
  localparam logic [2:0] EOP_SQD  = 3'd4;
  localparam logic [1:0] CFG_EOP   = 2'd0;
  localparam logic [1:0] CFG_AOP   = 2'd1;
  localparam logic [1:0] CFG_START = 2'd2;
  localparam logic [1:0] CFG_ROOT  = 2'd3;
endpackage

FILE: src/vector_pairwise_accumulate.sv
// Vector pairwise accumulate: element op, fold into total, optional square root.
// Each beat runs the element op and then the fold op on one shared serial datapath:
// an add or subtract is done in S_OP, a multiply is a shift-add in S_MUL and a quotient
// a restoring divide in S_DIV, each followed by S_FIN to hand over. A pair is not
// taken before the previous pair is through; after the last pair S_OUT presents the
// result, preceded by a two-bit-a-cycle restoring square root in S_ROOT in root mode
// for a non-negative total. in_tready is high only between pairs and while no result waits.
`include "vector_pairwise_accumulate_defines.svh"
module vector_pairwise_accumulate
  import vpa_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // elem_a [31:0], elem_b [63:32]
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // total
  output logic        out_tuser,  // fault
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  typedef enum logic [2:0] {S_IDLE, S_OP, S_MUL, S_DIV, S_FIN, S_ROOT, S_OUT} state_t;

  state_t state_r;
  logic [2:0]  eop_r;
  logic [1:0]  aop_r;
  logic signed [31:0] start_r, tot_r;
  logic root_r, fault_r, last_r, phase_r;
  logic [2:0] op_r;
  logic signed [63:0] x_r, y_r;
  // Shared serial datapath: accumulator/dividend, multiplicand/remainder, multiplier/quotient, counter.
  logic [63:0] acc_r, sh_r, q_r;
  logic [6:0] cnt_r;
  logic neg_r, sqbig_r;
  logic signed [31:0] res_r;
  logic [63:0] rt_n_r, rt_res_r;
  logic [31:0] out_total_r;
  logic out_fault_r, out_valid_r;

  function automatic logic signed [31:0] sat(input logic signed [63:0] v, output logic f);
    f = 1'b0;
    if (v > Max32) begin
      f = 1'b1;
      sat = 32'sh7fffffff;
    end else if (v < Min32) begin
      f = 1'b1;
      sat = 32'sh80000000;
    end else begin
      sat = v[31:0];
    end
  endfunction

  logic signed [63:0] sumdiff;
  logic [63:0] mag_x, mag_y, dtmp, trial, rt_try;
  logic signed [63:0] prod_s, quot_s;
  logic signed [31:0] sat_v;
  logic sat_f;

  always_comb begin
    sumdiff = (op_r == EOP_SUM) ? x_r + y_r : x_r - y_r;
    mag_x = x_r[63] ? 64'(-x_r) : 64'(x_r);
    mag_y = y_r[63] ? 64'(-y_r) : 64'(y_r);
    dtmp = x_r - y_r;
    prod_s = neg_r ? -$signed(acc_r) : $signed(acc_r);
    quot_s = neg_r ? -$signed(q_r) : $signed(q_r);
    trial = {sh_r[62:0], acc_r[63]};
    rt_try = rt_res_r + (64'd1 << {cnt_r[5:0], 1'b0});
    sat_v = '0;
    sat_f = 1'b0;
    if (state_r == S_OP) sat_v = sat(sumdiff, sat_f);
  end

  // Floor shift of a signed product; arithmetic shift floors directly.
  logic signed [63:0] prod_fl;
  assign prod_fl = prod_s >>> FRAC_BITS;

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_total_r;
  assign out_tuser = out_fault_r;

  always_ff @(posedge clk) begin
    logic signed [31:0] v;
    logic f;
    v = '0;
    f = 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      eop_r <= EOP_DIV;
      aop_r <= 2'd0;
      start_r <= '0;
      root_r <= 1'b0;
      tot_r <= '0;
      fault_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EOP: eop_r <= cfg_wdata[2:0];
          CFG_AOP: aop_r <= cfg_wdata[1:0];
          CFG_START: begin
            start_r <= cfg_wdata;
            tot_r <= cfg_wdata;
            fault_r <= 1'b0;
          end
          CFG_ROOT: root_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          x_r <= 64'(signed'(in_tdata[31:0]));
          y_r <= 64'(signed'(in_tdata[63:32]));
          op_r <= eop_r;
          last_r <= in_tlast;
          phase_r <= 1'b0;
          state_r <= S_OP;
        end
        S_OP: begin
          case (op_r)
            EOP_SUM, EOP_DIFF: begin
              res_r <= sat_v;
              fault_r <= fault_r | sat_f;
              state_r <= S_FIN;
            end
            EOP_MUL: begin
              neg_r <= x_r[63] ^ y_r[63];
              sh_r <= mag_x;
              q_r <= mag_y;
              acc_r <= '0;
              cnt_r <= '0;
              sqbig_r <= 1'b0;
              state_r <= S_MUL;
            end
            EOP_SQD: begin
              neg_r <= 1'b0;
              sqbig_r <= (dtmp[63] ? 64'(-dtmp) : dtmp) >= 64'h80000000;
              sh_r <= dtmp[63] ? 64'(-dtmp) : dtmp;
              q_r <= dtmp[63] ? 64'(-dtmp) : dtmp;
              acc_r <= '0;
              cnt_r <= '0;
              state_r <= S_MUL;
            end
            EOP_DIV: begin
              if (y_r == 0) begin
                res_r <= x_r[63] ? 32'sh80000000 : 32'sh7fffffff;
                fault_r <= 1'b1;
                state_r <= S_FIN;
              end else begin
                neg_r <= x_r[63] ^ y_r[63];
                acc_r <= mag_x << FRAC_BITS;
                sh_r <= '0;
                q_r <= '0;
                cnt_r <= '0;
                state_r <= S_DIV;
              end
            end
            default: begin
              res_r <= '0;
              state_r <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          if (q_r[0]) acc_r <= acc_r + sh_r;
          sh_r <= sh_r << 1;
          q_r <= q_r >> 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd32) begin
            if (sqbig_r) begin
              res_r <= 32'sh7fffffff;
              fault_r <= 1'b1;
            end else begin
              v = sat(prod_fl, f);
              res_r <= v;
              fault_r <= fault_r | f;
            end
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          if (cnt_r == 7'd64) begin
            v = sat(quot_s, f);
            res_r <= v;
            fault_r <= fault_r | f;
            state_r <= S_FIN;
          end else begin
            // Restoring divide: one quotient bit per cycle.
            acc_r <= acc_r << 1;
            if (trial >= mag_y) begin
              sh_r <= trial - mag_y;
              q_r <= {q_r[62:0], 1'b1};
            end else begin
              sh_r <= trial;
              q_r <= {q_r[62:0], 1'b0};
            end
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_FIN: begin
          if (!phase_r) begin
            // Fold: total op element, reusing the element datapath.
            phase_r <= 1'b1;
            x_r <= 64'(tot_r);
            y_r <= 64'(res_r);
            op_r <= {1'b0, aop_r};
            state_r <= S_OP;
          end else begin
            tot_r <= res_r;
            if (!last_r) begin
              state_r <= S_IDLE;
            end else if (root_r && !res_r[31]) begin
              rt_n_r <= 64'(res_r) << FRAC_BITS;
              rt_res_r <= '0;
              cnt_r <= 7'd31;
              state_r <= S_ROOT;
            end else begin
              out_total_r <= root_r ? -(32'sd1 <<< FRAC_BITS) : res_r;
              out_fault_r <= fault_r | root_r;
              state_r <= S_OUT;
            end
          end
        end
        S_ROOT: begin
          if (rt_n_r >= rt_try) begin
            rt_n_r <= rt_n_r - rt_try;
            rt_res_r <= (rt_res_r >> 1) + (64'd1 << {cnt_r[5:0], 1'b0});
          end else begin
            rt_res_r <= rt_res_r >> 1;
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) state_r <= S_OUT;
          if (cnt_r == 7'd0) begin
            out_total_r <= (rt_n_r >= rt_try) ? 32'((rt_res_r >> 1) + 64'd1)
                                             : 32'(rt_res_r >> 1);
            out_fault_r <= fault_r;
          end
        end
        S_OUT: if (!out_valid_r) begin
          out_valid_r <= 1'b1;
          tot_r <= start_r;
          fault_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VPA_ASSERT_IMP(a_ready_idle, in_tready, state_r == S_IDLE)
  `VPA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `VPA_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, !in_tready)
endmodule
